/* rtl/transition_gradient_window_assert.svh */
// Assertion macros shared by the transition gradient window RTL.
// Users must have i_clk and i_rst_n in scope; no other dependencies.
`ifndef TRANSITION_GRADIENT_WINDOW_ASSERT_SVH
`define TRANSITION_GRADIENT_WINDOW_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TGW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define TGW_ASSERT_NEVER(lbl, cond, msg) \
    `TGW_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/tgw_pkg.sv */
// Package for the transition gradient window: item types, config struct and constants.
// No dependencies; imported by the top, front and back modules of the block.
`default_nettype none

package tgw_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 16;
    localparam int COL_OUT_W   = 11;
    localparam int NB_N        = 8;
    localparam int WIN_N       = 9;
    localparam int CENTER      = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [WIN_N-1:0] t_win;

    // Neighbor scan order as window positions: UL, U, UR, L, R, LL, D, LR.
    localparam logic [3:0] NB_ORDER [NB_N] = '{4'd0, 4'd1, 4'd2, 4'd3,
                                               4'd5, 4'd6, 4'd7, 4'd8};

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_NEIGHBOR_COUNT = 2'd2,
        CFG_STEP_LIMIT     = 2'd3
    } t_cfg_idx;

    // Configuration after clamping to the meaningful ranges.
    typedef struct packed {
        logic [11:0]      col_last;
        logic [ROW_W-1:0] row_last;
        logic [3:0]       nb_count;
        logic [7:0]       step_limit;
    } t_cfg;

    typedef struct packed {
        t_win                 win;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 last;
    } t_mid_item;

    typedef struct packed {
        t_pix                 gradient;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 last;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/transition_gradient_window.sv */
// Transition gradient window: one pixel per cycle in while full is low, one result per interior pixel out.
// Throughput: 1 pixel per cycle while full is low, set by the read-first line stores and window.
// Reset clears counters, window, queues and configuration (2048, 1024, 8, 3); the line
// stores are not cleared and need no clearing pass, so pixels are taken right after reset.
`default_nettype none

module transition_gradient_window
    import tgw_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire t_pix                 i_pixel_value,
    output logic                      empty,
    input  wire logic                 pop,
    output t_pix                      o_gradient,
    output logic [ROW_W-1:0]          o_center_row,
    output logic [COL_OUT_W-1:0]      o_center_col,
    output logic                      o_frame_last
);

    localparam int          RST_W        = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
    localparam logic [11:0] RST_COL_LAST = 12'(RST_W - 1);

    t_cfg r_cfg, n_cfg;

    logic                        accept;
    logic                        mid_push, mid_pop, mid_empty;
    logic [QCNT_W-1:0]           mid_count;
    t_mid_item                   mid_in, mid_out;
    logic [$bits(t_mid_item)-1:0] mid_data;

    logic                        out_push;
    logic [QCNT_W-1:0]           out_count;
    t_out_item                   out_in, out_head;
    logic [$bits(t_out_item)-1:0] out_data;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH: begin
                    if (i_cfg_data[11:0] < 12'd3) begin
                        n_cfg.col_last = 12'd2;
                    end else if (int'(i_cfg_data[11:0]) > MAX_WIDTH) begin
                        n_cfg.col_last = 12'(MAX_WIDTH - 1);
                    end else begin
                        n_cfg.col_last = i_cfg_data[11:0] - 12'd1;
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    n_cfg.row_last = (i_cfg_data < 16'd3) ? 16'd2 : i_cfg_data - 16'd1;
                end
                CFG_NEIGHBOR_COUNT: begin
                    n_cfg.nb_count = (i_cfg_data[3:0] > 4'd8) ? 4'd8 : i_cfg_data[3:0];
                end
                CFG_STEP_LIMIT: begin
                    n_cfg.step_limit = i_cfg_data[7:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.col_last   <= RST_COL_LAST;
            r_cfg.row_last   <= 16'd1023;
            r_cfg.nb_count   <= 4'd8;
            r_cfg.step_limit <= 8'd3;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign accept = push && !full;

    tgw_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (accept),
        .i_pixel   (i_pixel_value),
        .i_q_count (mid_count),
        .o_full    (full),
        .o_push    (mid_push),
        .o_item    (mid_in)
    );

    tgw_queue #(
        .WIDTH ($bits(t_mid_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .i_pop   (mid_pop),
        .o_data  (mid_data),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign mid_out = t_mid_item'(mid_data);

    tgw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (mid_empty),
        .i_item     (mid_out),
        .i_oq_count (out_count),
        .o_q_pop    (mid_pop),
        .o_push     (out_push),
        .o_item     (out_in)
    );

    tgw_queue #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .i_pop   (pop && !empty),
        .o_data  (out_data),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign out_head     = t_out_item'(out_data);
    assign o_gradient   = out_head.gradient;
    assign o_center_row = out_head.row;
    assign o_center_col = out_head.col;
    assign o_frame_last = out_head.last;

endmodule

`default_nettype wire

/* rtl/tgw_queue.sv */
// Small register FIFO used between the front and back parts and at the output.
// Depends on transition_gradient_window_assert.svh; DEPTH must be a power of two.
`default_nettype none
`include "transition_gradient_window_assert.svh"

module tgw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_data,
    input  wire logic                         i_pop,
    output logic      [WIDTH-1:0]             o_data,
    output logic                              o_empty,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CNTW-1:0]  r_count, n_count;

    always_comb begin
        n_wr    = i_push ? r_wr + PW'(1) : r_wr;
        n_rd    = i_pop  ? r_rd + PW'(1) : r_rd;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    `TGW_ASSERT_NEVER(a_no_overflow, i_push && !i_pop && (r_count == CNTW'(DEPTH)), "queue overflow")
    `TGW_ASSERT_NEVER(a_no_underflow, i_pop && (r_count == '0), "queue underflow")
    `TGW_ASSERT(a_count_up, (i_push && !i_pop) |=> (r_count == $past(r_count) + CNTW'(1)), "count lost a push")

endmodule

`default_nettype wire

/* rtl/tgw_front.sv */
// Front part: raster position counters, two line stores, the 3x3 window and
// classification of interior pixels. Depends on tgw_pkg and the assertion header.
`default_nettype none
`include "transition_gradient_window_assert.svh"

module tgw_front
    import tgw_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    input  wire t_pix              i_pixel,
    input  wire logic [QCNT_W-1:0] i_q_count,
    output logic                   o_full,
    output logic                   o_push,
    output t_mid_item              o_item
);

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;

    t_pix             r_older [MAX_WIDTH];
    t_pix             r_newer [MAX_WIDTH];
    t_pix             r_up2, r_up1;

    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_win             r_win, n_win;

    logic                 r_s1_v;
    t_pix                 r_s1_pix;
    logic [CW-1:0]        r_s1_col;
    logic                 r_s1_emit;
    logic [ROW_W-1:0]     r_s1_row;
    logic [COL_OUT_W-1:0] r_s1_ccol;
    logic                 r_s1_last;

    logic line_end, frame_end, emit;

    // Space is reserved for the item in flight as well as the new one.
    assign o_full = (int'(i_q_count) + int'(r_s1_v)) >= QUEUE_DEPTH;

    always_comb begin
        line_end  = int'(r_col) >= int'(i_cfg.col_last);
        frame_end = r_row >= i_cfg.row_last;
        emit      = (r_row >= ROW_W'(2)) && (int'(r_col) >= 2);
        n_col     = r_col;
        n_row     = r_row;
        if (i_valid) begin
            if (line_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    // Window shifts left; the new right column is the two stored lines and the pixel.
    always_comb begin
        n_win = r_win;
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3 + 1];
            n_win[r*3 + 1] = r_win[r*3 + 2];
        end
        n_win[2] = r_up2;
        n_win[5] = r_up1;
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_win  <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_s1_v <= i_valid;
            if (r_s1_v) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s1_pix  <= i_pixel;
            r_s1_col  <= r_col;
            r_s1_emit <= emit;
            r_s1_row  <= r_row - ROW_W'(1);
            r_s1_ccol <= COL_OUT_W'(int'(r_col) - 1);
            r_s1_last <= line_end && frame_end;
        end
    end

    // Read-first line stores: the newer line is read and overwritten in the same
    // cycle; the older line takes the old newer-line value in the following cycle.
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_up2          <= r_older[r_col];
            r_up1          <= r_newer[r_col];
            r_newer[r_col] <= i_pixel;
        end
        if (r_s1_v) begin
            r_older[r_s1_col] <= r_up1;
        end
    end

    assign o_push      = r_s1_v && r_s1_emit;
    assign o_item.win  = n_win;
    assign o_item.row  = r_s1_row;
    assign o_item.col  = r_s1_ccol;
    assign o_item.last = r_s1_last;

    `TGW_ASSERT(a_accept_advances, i_valid |=> r_s1_v, "accepted pixel did not advance")
    `TGW_ASSERT(a_line_wrap, (i_valid && line_end) |=> (r_col == '0), "line end did not wrap column")
    `TGW_ASSERT_NEVER(a_emit_row, o_push && (r_s1_row == '0), "result for a border row")

endmodule

`default_nettype wire

/* rtl/tgw_back.sv */
// Back part: per-neighbor classification against the center, then the
// low/high reduction and the gradient. Depends on tgw_pkg.
`default_nettype none

module tgw_back
    import tgw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_q_empty,
    input  wire t_mid_item         i_item,
    input  wire logic [QCNT_W-1:0] i_oq_count,
    output logic                   o_q_pop,
    output logic                   o_push,
    output t_out_item              o_item
);

    typedef struct packed {
        logic v;
        t_pix x;
    } t_cand;

    logic            r_b1_v;
    t_mid_item       r_b1_item;
    logic [NB_N-1:0] r_lo_ok, r_hi_ok;
    logic [NB_N-1:0] lo_ok, hi_ok;

    t_cand lo1 [4];
    t_cand hi1 [4];
    t_cand lo2 [2];
    t_cand hi2 [2];
    t_cand lo3, hi3;

    function automatic t_cand pick_low(t_cand a, t_cand b);
        t_cand r;
        if (a.v && b.v) begin
            r = (a.x > b.x) ? a : b;
        end else begin
            r = a.v ? a : b;
        end
        return r;
    endfunction

    function automatic t_cand pick_high(t_cand a, t_cand b);
        t_cand r;
        if (a.v && b.v) begin
            r = (a.x < b.x) ? a : b;
        end else begin
            r = a.v ? a : b;
        end
        return r;
    endfunction

    assign o_q_pop = !i_q_empty && ((int'(i_oq_count) + int'(r_b1_v)) < QUEUE_DEPTH);

    always_comb begin
        t_pix ctr;
        t_pix v;
        logic en;
        ctr = i_item.win[CENTER];
        for (int i = 0; i < NB_N; i++) begin
            v        = i_item.win[NB_ORDER[i]];
            en       = i < int'(i_cfg.nb_count);
            lo_ok[i] = en && (v < ctr) && ((ctr - v) <= i_cfg.step_limit);
            hi_ok[i] = en && (v > ctr) && ((v - ctr) <= i_cfg.step_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
        end else begin
            r_b1_v <= o_q_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b1_item <= i_item;
            r_lo_ok   <= lo_ok;
            r_hi_ok   <= hi_ok;
        end
    end

    // Three-level tree over the eight candidates.
    always_comb begin
        t_cand la, lb, ha, hb;
        for (int i = 0; i < 4; i++) begin
            la     = '{v: r_lo_ok[2*i],     x: r_b1_item.win[NB_ORDER[2*i]]};
            lb     = '{v: r_lo_ok[2*i + 1], x: r_b1_item.win[NB_ORDER[2*i + 1]]};
            ha     = '{v: r_hi_ok[2*i],     x: r_b1_item.win[NB_ORDER[2*i]]};
            hb     = '{v: r_hi_ok[2*i + 1], x: r_b1_item.win[NB_ORDER[2*i + 1]]};
            lo1[i] = pick_low(la, lb);
            hi1[i] = pick_high(ha, hb);
        end
        for (int i = 0; i < 2; i++) begin
            lo2[i] = pick_low(lo1[2*i], lo1[2*i + 1]);
            hi2[i] = pick_high(hi1[2*i], hi1[2*i + 1]);
        end
        lo3 = pick_low(lo2[0], lo2[1]);
        hi3 = pick_high(hi2[0], hi2[1]);
    end

    assign o_push          = r_b1_v;
    assign o_item.gradient = (lo3.v && hi3.v) ? hi3.x - lo3.x : t_pix'(8'hFF);
    assign o_item.row      = r_b1_item.row;
    assign o_item.col      = r_b1_item.col;
    assign o_item.last     = r_b1_item.last;

endmodule

`default_nettype wire
